>>> design/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/lbpc_pkg.sv
`timescale 1ns / 1ps

package lbpc_pkg;

  // line store geometry
  localparam int LINE_CELLS = 160;
  localparam int NUM_GROUPS = LINE_CELLS / 4;
  localparam int CELL_AW    = $clog2(LINE_CELLS);
  localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int CELL_W     = 5;

  // colour registers
  localparam int NUM_COLORS = 32;
  localparam int COL_AW     = $clog2(NUM_COLORS);
  localparam int PIX_W      = 8;

  // command queue between front and back
  localparam int CMD_DEPTH  = 2;

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_KILL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KANGAROO     = 2'd2;

  // display modes
  localparam logic [1:0] DM_DOUBLE_A = 2'd0;
  localparam logic [1:0] DM_DOUBLE_B = 2'd1;
  localparam logic [1:0] DM_SPLIT    = 2'd2;
  localparam logic [1:0] DM_PAIR     = 2'd3;

  typedef enum logic [1:0] {
    MODE_STORE = 2'd0,
    MODE_COLOR = 2'd1,
    MODE_EMIT  = 2'd2
  } item_mode_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_STORE,
    BK_EMIT_RUN,
    BK_EMIT_OUT
  } back_state_e;

  typedef struct packed {
    logic [1:0] display_mode;
    logic       color_kill;
    logic       kangaroo;
  } lbpc_cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] graphic_byte;
    logic       object_start;
    logic [7:0] start_position;
    logic [2:0] palette_select;
    logic       wide_mode;
    logic       hole_skip;
    logic [4:0] color_index;
  } lbpc_item_t;

  typedef struct packed {
    item_mode_e                 op;
    logic [7:0]                 pos;
    logic [3:0][CELL_W-1:0]     cells;
    logic [3:0]                 wr;
    logic [1:0]                 last_k;
    logic [PIX_W-1:0]           color_val;
    logic [COL_AW-1:0]          color_idx;
  } lbpc_cmd_t;

  typedef struct packed {
    logic [5:0]            group_index;
    logic [7:0][PIX_W-1:0] pix;
    logic                  last_group;
  } lbpc_out_t;

endpackage

>>> design/lbpc_if.sv
`timescale 1ns / 1ps

// Input channel: one item per word.
interface lbpc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] graphic_byte;
  logic       object_start;
  logic [7:0] start_position;
  logic [2:0] palette_select;
  logic       wide_mode;
  logic       hole_skip;
  logic [4:0] color_index;

  modport source (
    output valid, mode, graphic_byte, object_start, start_position,
           palette_select, wide_mode, hole_skip, color_index,
    input  ready
  );
  modport sink (
    input  valid, mode, graphic_byte, object_start, start_position,
           palette_select, wide_mode, hole_skip, color_index,
    output ready
  );
endinterface

// Output channel: one group of eight pixels per word.
interface lbpc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] group_index;
  logic [7:0] pixel_0;
  logic [7:0] pixel_1;
  logic [7:0] pixel_2;
  logic [7:0] pixel_3;
  logic [7:0] pixel_4;
  logic [7:0] pixel_5;
  logic [7:0] pixel_6;
  logic [7:0] pixel_7;
  logic       last_group;

  modport source (
    output valid, group_index, pixel_0, pixel_1, pixel_2, pixel_3,
           pixel_4, pixel_5, pixel_6, pixel_7, last_group,
    input  ready
  );
  modport sink (
    input  valid, group_index, pixel_0, pixel_1, pixel_2, pixel_3,
           pixel_4, pixel_5, pixel_6, pixel_7, last_group,
    output ready
  );
endinterface

>>> design/lbpc_front.sv
`timescale 1ns / 1ps

// Accepts items, tracks the write position, unpacks store bytes into cells.
module lbpc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lbpc_pkg::lbpc_cfg_t   cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lbpc_pkg::lbpc_item_t  item_i,
  input  logic                  full_i,
  output logic                  push_o,
  output lbpc_pkg::lbpc_cmd_t   cmd_o
);

  logic [7:0]       wpos_q, wpos_d;
  logic             accept;
  logic             is_store;
  logic [7:0]       base;
  logic [3:0][7:0]  addr;
  logic [3:0]       in_line;
  logic [3:0][lbpc_pkg::CELL_W-1:0] cells;
  logic [3:0]       wr;
  logic [2:0]       pal;
  logic [7:0]       d;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_store   = (item_i.mode == lbpc_pkg::MODE_STORE);
  assign pal        = item_i.palette_select;
  assign d          = item_i.graphic_byte;

  always_comb begin
    base = item_i.object_start ? item_i.start_position : wpos_q;
    for (int k = 0; k < 4; k++) begin
      addr[k]    = base + 8'(k);
      in_line[k] = ({1'b0, addr[k]} < 9'(lbpc_pkg::LINE_CELLS));
    end
  end

  // wide: high pair from one nibble, low pair from the other
  // narrow: a transparent pair becomes an all-zero cell (kept only under kangaroo)
  always_comb begin
    if (item_i.wide_mode) begin
      cells[0] = {pal[2], d[3:2], d[7:6]};
      cells[1] = {pal[2], d[1:0], d[5:4]};
      cells[2] = '0;
      cells[3] = '0;
    end else begin
      cells[0] = (d[7:6] != 2'b00) ? {pal, d[7:6]} : '0;
      cells[1] = (d[5:4] != 2'b00) ? {pal, d[5:4]} : '0;
      cells[2] = (d[3:2] != 2'b00) ? {pal, d[3:2]} : '0;
      cells[3] = (d[1:0] != 2'b00) ? {pal, d[1:0]} : '0;
    end
    for (int k = 0; k < 4; k++) begin
      wr[k] = in_line[k] && ((cells[k][1:0] != 2'b00) || cfg_i.kangaroo)
              && (!item_i.wide_mode || (k < 2));
    end
  end

  always_comb begin
    wpos_d = wpos_q;
    if (accept && is_store) begin
      wpos_d = base + (item_i.wide_mode ? 8'd2 : 8'd4);
    end
  end

  always_comb begin
    push_o = 1'b0;
    if (accept) begin
      unique case (item_i.mode)
        lbpc_pkg::MODE_STORE: push_o = !item_i.hole_skip;
        lbpc_pkg::MODE_COLOR: push_o = 1'b1;
        lbpc_pkg::MODE_EMIT:  push_o = 1'b1;
        default:              push_o = 1'b0;
      endcase
    end
  end

  always_comb begin
    cmd_o.op        = lbpc_pkg::item_mode_e'(item_i.mode);
    cmd_o.pos       = base;
    cmd_o.cells     = cells;
    cmd_o.wr        = wr;
    cmd_o.last_k    = item_i.wide_mode ? 2'd1 : 2'd3;
    cmd_o.color_val = item_i.graphic_byte;
    cmd_o.color_idx = item_i.color_index;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
    end else begin
      wpos_q <= wpos_d;
    end
  end

endmodule

>>> design/lbpc_cmd_fifo.sv
`timescale 1ns / 1ps

// Short command queue between front and back.
module lbpc_cmd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lbpc_pkg::lbpc_cmd_t  cmd_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 head_valid_o,
  output lbpc_pkg::lbpc_cmd_t  head_o
);

  localparam int PTR_W = (lbpc_pkg::CMD_DEPTH > 1) ? $clog2(lbpc_pkg::CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(lbpc_pkg::CMD_DEPTH + 1);

  lbpc_pkg::lbpc_cmd_t entry_q [lbpc_pkg::CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o       = (cnt_q == CNT_W'(lbpc_pkg::CMD_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(lbpc_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(lbpc_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> design/lbpc_back.sv
`timescale 1ns / 1ps

// Executes commands: cell writes, colour writes, line readout.
module lbpc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lbpc_pkg::lbpc_cfg_t  cfg_i,
  input  logic                 head_valid_i,
  input  lbpc_pkg::lbpc_cmd_t  head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lbpc_pkg::lbpc_out_t  out_o
);

  localparam int CW = lbpc_pkg::CELL_W;
  localparam int CA = lbpc_pkg::CELL_AW;
  localparam int GW = lbpc_pkg::GRP_W;
  localparam int PW = lbpc_pkg::PIX_W;
  localparam int KA = lbpc_pkg::COL_AW;

  // pixel index from a cell, per display mode
  function automatic logic [CW-1:0] idx_a(logic [1:0] dm, logic [CW-1:0] c);
    logic [CW-1:0] r;
    unique case (dm)
      lbpc_pkg::DM_SPLIT: r = {c[4], 2'b00, c[1], c[3]};
      lbpc_pkg::DM_PAIR:  r = {c[4:1], 1'b0};
      default:            r = c;
    endcase
    return r;
  endfunction

  function automatic logic [CW-1:0] idx_b(logic [1:0] dm, logic [CW-1:0] c);
    logic [CW-1:0] r;
    unique case (dm)
      lbpc_pkg::DM_SPLIT: r = {c[4], 2'b00, c[0], c[2]};
      lbpc_pkg::DM_PAIR:  r = {c[4:2], c[0], 1'b0};
      default:            r = c;
    endcase
    return r;
  endfunction

  // transparent index reads background register
  function automatic logic [KA-1:0] bg_fold(logic [CW-1:0] i);
    return (i[1:0] != 2'b00) ? KA'(i) : '0;
  endfunction

  function automatic logic [PW-1:0] kill(logic k, logic [PW-1:0] p);
    return k ? {4'h0, p[3:0]} : p;
  endfunction

  lbpc_pkg::back_state_e state_q, state_d;
  lbpc_pkg::lbpc_cmd_t   cmd_q;

  logic [CW-1:0] cell_mem [lbpc_pkg::LINE_CELLS];
  logic [lbpc_pkg::LINE_CELLS-1:0] cell_vld_q;
  logic [PW-1:0] col_mem [lbpc_pkg::NUM_COLORS];
  logic [lbpc_pkg::NUM_COLORS-1:0] col_vld_q;

  logic [1:0]    k_q;
  logic [GW-1:0] grp_q;
  logic [2:0]    rd_k_q;
  logic          s1_v_q, s2_v_q;
  logic [1:0]    s1_k_q, s2_k_q;
  logic [CW-1:0] cell_rd_q;
  logic          cell_rdv_q;
  logic [PW-1:0] col_a_q, col_b_q;
  logic          col_av_q, col_bv_q;
  logic [7:0][PW-1:0] pix_q;
  logic          out_valid_q;
  lbpc_pkg::lbpc_out_t out_q;

  logic          start_store, start_emit, col_we;
  logic          st_we, rd_en, out_free, out_load, grp_last, grp_done;
  logic [7:0]    st_sum;
  logic [CA-1:0] st_addr, rd_addr;
  logic [CW-1:0] rd_cell;
  logic [KA-1:0] ia, ib;
  logic [PW-1:0] pa, pb;

  assign out_free = !out_valid_q || out_ready_i;
  assign grp_last = (grp_q == GW'(lbpc_pkg::NUM_GROUPS - 1));
  assign grp_done = s2_v_q && (s2_k_q == 2'd3);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lbpc_pkg::BK_IDLE: begin
        if (head_valid_i && head_i.op == lbpc_pkg::MODE_STORE) begin
          state_d = lbpc_pkg::BK_STORE;
        end else if (head_valid_i && head_i.op == lbpc_pkg::MODE_EMIT) begin
          state_d = lbpc_pkg::BK_EMIT_RUN;
        end
      end
      lbpc_pkg::BK_STORE: begin
        if (k_q == cmd_q.last_k) state_d = lbpc_pkg::BK_IDLE;
      end
      lbpc_pkg::BK_EMIT_RUN: begin
        if (grp_done) state_d = lbpc_pkg::BK_EMIT_OUT;
      end
      lbpc_pkg::BK_EMIT_OUT: begin
        if (out_free) state_d = grp_last ? lbpc_pkg::BK_IDLE : lbpc_pkg::BK_EMIT_RUN;
      end
      default: state_d = lbpc_pkg::BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop_o    = 1'b0;
    st_we    = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      lbpc_pkg::BK_IDLE:     pop_o    = head_valid_i;
      lbpc_pkg::BK_STORE:    st_we    = cmd_q.wr[k_q];
      lbpc_pkg::BK_EMIT_RUN: rd_en    = !rd_k_q[2];
      lbpc_pkg::BK_EMIT_OUT: out_load = out_free;
      default: ;
    endcase
  end

  assign start_store = pop_o && (head_i.op == lbpc_pkg::MODE_STORE);
  assign start_emit  = pop_o && (head_i.op == lbpc_pkg::MODE_EMIT);
  assign col_we      = pop_o && (head_i.op == lbpc_pkg::MODE_COLOR);

  assign st_sum  = cmd_q.pos + 8'(k_q);
  assign st_addr = st_sum[CA-1:0];
  assign rd_addr = CA'({grp_q, rd_k_q[1:0]});

  // stage 1: cell to colour indexes
  always_comb begin
    rd_cell = cell_rdv_q ? cell_rd_q : '0;
    ia      = bg_fold(idx_a(cfg_i.display_mode, rd_cell));
    ib      = bg_fold(idx_b(cfg_i.display_mode, rd_cell));
  end

  // stage 2: colour values
  assign pa = kill(cfg_i.color_kill, col_av_q ? col_a_q : '0);
  assign pb = kill(cfg_i.color_kill, col_bv_q ? col_b_q : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbpc_pkg::BK_IDLE;
      k_q         <= '0;
      grp_q       <= '0;
      rd_k_q      <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cell_vld_q  <= '0;
      col_vld_q   <= '0;
    end else begin
      state_q <= state_d;
      s1_v_q  <= rd_en;
      s2_v_q  <= s1_v_q;
      if (start_store) begin
        k_q <= '0;
      end else if (state_q == lbpc_pkg::BK_STORE) begin
        k_q <= k_q + 1'b1;
      end
      if (start_emit) begin
        grp_q  <= '0;
        rd_k_q <= '0;
      end else if (out_load && !grp_last) begin
        grp_q  <= grp_q + 1'b1;
        rd_k_q <= '0;
      end else if (rd_en) begin
        rd_k_q <= rd_k_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // store is cleared when the last group is loaded into the output register
      if (out_load && grp_last) begin
        cell_vld_q <= '0;
      end else if (st_we) begin
        cell_vld_q[st_addr] <= 1'b1;
      end
      if (col_we) begin
        col_vld_q[head_i.color_idx] <= 1'b1;
      end
    end
  end

  // line store
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      cell_mem[st_addr] <= cmd_q.cells[k_q];
    end
    cell_rd_q  <= cell_mem[rd_addr];
    cell_rdv_q <= cell_vld_q[rd_addr];
  end

  // colour registers, two read ports
  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[head_i.color_idx] <= head_i.color_val;
    end
    col_a_q  <= col_mem[ia];
    col_b_q  <= col_mem[ib];
    col_av_q <= col_vld_q[ia];
    col_bv_q <= col_vld_q[ib];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i;
    end
    s1_k_q <= rd_k_q[1:0];
    s2_k_q <= s1_k_q;
    if (s2_v_q) begin
      pix_q[{s2_k_q, 1'b0}] <= pa;
      pix_q[{s2_k_q, 1'b1}] <= pb;
    end
    if (out_load) begin
      out_q.group_index <= 6'(grp_q);
      out_q.pix         <= pix_q;
      out_q.last_group  <= grp_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> design/line_buffer_pixel_composer.sv
`timescale 1ns / 1ps

// Line buffer pixel composer. Store words unpack one graphics byte into
// four narrow or two wide 5-bit cells of a 160-cell line store at an 8-bit
// write position that wraps; cells past the line are dropped. Colour words
// load one of 32 colour registers. An emit word reads the line out as 40
// words of eight palette-mapped pixels (group_index 0..39, last_group on
// the final one) and then clears the store. Mode 3 words are taken and
// dropped. Input words are taken into a two-deep command queue; hole-skip
// stores and mode 3 words are not queued. The back end writes a colour
// register straight from the queue head and writes stores one cell per
// cycle through the single store write port. An emit handles each group
// with four store reads, two pipeline stages and one output load, one
// group at a time through the single read port of the line store. A held
// output word stalls the back end; the input stalls once the command queue
// is full. Reset leaves the store and colour registers reading as zero
// with no clearing pass. The user must write display_mode, color_kill and
// kangaroo only while idle; the block itself does not enforce this.
module line_buffer_pixel_composer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  lbpc_in_if.sink                             in_i,
  lbpc_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [lbpc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lbpc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  lbpc_pkg::lbpc_cfg_t  cfg_q;
  lbpc_pkg::lbpc_item_t item;
  lbpc_pkg::lbpc_cmd_t  push_cmd, head_cmd;
  lbpc_pkg::lbpc_out_t  out_word;
  logic                 push, full, pop, head_valid, out_valid;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lbpc_pkg::CFG_DISPLAY_MODE: cfg_q.display_mode <= cfg_wdata_i[1:0];
        lbpc_pkg::CFG_COLOR_KILL:   cfg_q.color_kill   <= cfg_wdata_i[0];
        lbpc_pkg::CFG_KANGAROO:     cfg_q.kangaroo     <= cfg_wdata_i[0];
        default: ;  // unmapped index, write ignored
      endcase
    end
  end

  always_comb begin
    item.mode           = in_i.mode;
    item.graphic_byte   = in_i.graphic_byte;
    item.object_start   = in_i.object_start;
    item.start_position = in_i.start_position;
    item.palette_select = in_i.palette_select;
    item.wide_mode      = in_i.wide_mode;
    item.hole_skip      = in_i.hole_skip;
    item.color_index    = in_i.color_index;
  end

  // front: accept, position tracking, byte unpack
  lbpc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .item_i     (item),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // decouples word intake from the multi-cycle back end
  lbpc_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (push_cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_cmd)
  );

  // back: line store, colour registers, readout pipeline, output register
  lbpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_o.ready),
    .out_o        (out_word)
  );

  assign out_o.valid       = out_valid;
  assign out_o.group_index = out_word.group_index;
  assign out_o.pixel_0     = out_word.pix[0];
  assign out_o.pixel_1     = out_word.pix[1];
  assign out_o.pixel_2     = out_word.pix[2];
  assign out_o.pixel_3     = out_word.pix[3];
  assign out_o.pixel_4     = out_word.pix[4];
  assign out_o.pixel_5     = out_word.pix[5];
  assign out_o.pixel_6     = out_word.pix[6];
  assign out_o.pixel_7     = out_word.pix[7];
  assign out_o.last_group  = out_word.last_group;

endmodule

>>> design/lbpc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on the output side.
module lbpc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic [lbpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [lbpc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [5:0]                      group_index_i,
  input logic [7:0]                      pixel_0_i,
  input logic [7:0]                      pixel_1_i,
  input logic [7:0]                      pixel_2_i,
  input logic [7:0]                      pixel_3_i,
  input logic [7:0]                      pixel_4_i,
  input logic [7:0]                      pixel_5_i,
  input logic [7:0]                      pixel_6_i,
  input logic [7:0]                      pixel_7_i,
  input logic                            last_group_i
);

  logic       kill_q;
  logic       out_acc;
  logic [3:0] hi_or;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kill_q <= 1'b0;
    end else if (cfg_we_i && cfg_idx_i == lbpc_pkg::CFG_COLOR_KILL) begin
      kill_q <= cfg_wdata_i[0];
    end
  end

  assign out_acc = out_valid_i && out_ready_i;
  assign hi_or   = pixel_0_i[7:4] | pixel_1_i[7:4] | pixel_2_i[7:4] | pixel_3_i[7:4]
                 | pixel_4_i[7:4] | pixel_5_i[7:4] | pixel_6_i[7:4] | pixel_7_i[7:4];

  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(group_index_i) && $stable(pixel_0_i) && $stable(pixel_7_i))
  `ASSERT_IMP(a_last_flag, clk_i, rst_ni, out_valid_i, last_group_i == (group_index_i == 6'(lbpc_pkg::NUM_GROUPS - 1)))
  `ASSERT_IMP(a_grp_range, clk_i, rst_ni, out_valid_i, group_index_i < 6'(lbpc_pkg::NUM_GROUPS - 1) || group_index_i == 6'(lbpc_pkg::NUM_GROUPS - 1))
  `ASSERT_IMP(a_grp_seq, clk_i, rst_ni, out_valid_i && $past(out_acc && !last_group_i), group_index_i == 6'($past(group_index_i) + 6'd1))
  `ASSERT_IMP(a_kill_mask, clk_i, rst_ni, out_valid_i && kill_q, hi_or == 4'h0)

endmodule

bind line_buffer_pixel_composer lbpc_checker u_lbpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_idx_i     (cfg_idx_i),
  .cfg_wdata_i   (cfg_wdata_i),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .group_index_i (out_o.group_index),
  .pixel_0_i     (out_o.pixel_0),
  .pixel_1_i     (out_o.pixel_1),
  .pixel_2_i     (out_o.pixel_2),
  .pixel_3_i     (out_o.pixel_3),
  .pixel_4_i     (out_o.pixel_4),
  .pixel_5_i     (out_o.pixel_5),
  .pixel_6_i     (out_o.pixel_6),
  .pixel_7_i     (out_o.pixel_7),
  .last_group_i  (out_o.last_group)
);

>>> tb/line_buffer_pixel_composer_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the line buffer pixel composer.
// A local line store / colour table copy predicts every group word of an
// emit; the checker compares each accepted group word with the oldest
// prediction.
module line_buffer_pixel_composer_test;
  import lbpc_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 11;
  // lets the back end retire queued stores after the last group is taken
  localparam int SETTLE_CYCLES   = 32;
  // long output hold-off, well past what the two-deep command queue absorbs
  localparam int HOLD_CYCLES     = 400;
  localparam int ITEMS_PER_PHASE = 130;
  // mode code with no function: taken and dropped by the block
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  lbpc_in_if  in_ch ();
  lbpc_out_if out_ch ();

  line_buffer_pixel_composer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predicted block state
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0] line_cells [LINE_CELLS];
  logic [7:0]        pen_pos;
  logic [PIX_W-1:0]  color_regs [NUM_COLORS];
  logic [1:0]        disp_mode;
  logic              kill_color;
  logic              kangaroo_on;

  // group words still owed by the block, oldest first
  lbpc_out_t pending_groups [$];

  int mismatches    = 0;
  int words_sent    = 0;
  int src_idle_pct  = 0;
  int snk_idle_pct  = 0;
  int hold_requests = 0;
  int holds_done    = 0;
  logic hold_on     = 1'b0;

  // Write one cell at the pen, drop it past the line, always advance (wraps
  // at 8 bits).
  function automatic void place_cell(logic [CELL_W-1:0] v, bit wr_en);
    if (pen_pos < LINE_CELLS && wr_en) line_cells[pen_pos] = v;
    pen_pos = pen_pos + 8'd1;
  endfunction

  // An index with zero low pair falls back to background register 0.
  function automatic logic [PIX_W-1:0] palette_color(logic [4:0] idx);
    return color_regs[(idx[1:0] != 2'b00) ? idx : 5'd0];
  endfunction

  // Apply one accepted word to the predicted state; an emit queues its 40
  // group words and clears the store.
  function automatic void model_word(lbpc_item_t it);
    logic [1:0]        pair;
    logic [CELL_W-1:0] cval;
    logic [PIX_W-1:0]  a;
    logic [PIX_W-1:0]  b;
    logic [PIX_W-1:0]  mask;
    lbpc_out_t         grp;
    int                g;
    int                k;
    case (it.mode)
      MODE_STORE: begin
        if (it.object_start) pen_pos = it.start_position;
        if (it.hole_skip) begin
          pen_pos = pen_pos + (it.wide_mode ? 8'd2 : 8'd4);
        end else if (it.wide_mode) begin
          // wide cell: high palette bit plus two pixel pairs interleaved
          cval = {it.palette_select[2], it.graphic_byte[3:2], it.graphic_byte[7:6]};
          place_cell(cval, cval[1:0] != 2'b00 || kangaroo_on);
          cval = {it.palette_select[2], it.graphic_byte[1:0], it.graphic_byte[5:4]};
          place_cell(cval, cval[1:0] != 2'b00 || kangaroo_on);
        end else begin
          // narrow: four pairs, msb pair first; zero pair is transparent
          for (k = 3; k >= 0; k--) begin
            pair = it.graphic_byte[2*k +: 2];
            cval = (pair != 2'b00) ? {it.palette_select, pair} : '0;
            place_cell(cval, pair != 2'b00 || kangaroo_on);
          end
        end
      end
      MODE_COLOR: color_regs[it.color_index] = it.graphic_byte;
      MODE_EMIT: begin
        mask = kill_color ? 8'h0F : 8'hFF;
        for (g = 0; g < NUM_GROUPS; g++) begin
          grp.group_index = 6'(g);
          grp.last_group  = (g == NUM_GROUPS - 1);
          for (k = 0; k < 4; k++) begin
            cval = line_cells[g*4 + k];
            case (disp_mode)
              DM_SPLIT: begin
                a = palette_color({cval[4], 2'b00, cval[1], cval[3]});
                b = palette_color({cval[4], 2'b00, cval[0], cval[2]});
              end
              DM_PAIR: begin
                a = palette_color({cval[4:1], 1'b0});
                b = palette_color({cval[4:2], cval[0], 1'b0});
              end
              default: begin
                a = palette_color(cval);
                b = a;
              end
            endcase
            grp.pix[2*k]     = a & mask;
            grp.pix[2*k + 1] = b & mask;
          end
          pending_groups.push_back(grp);
        end
        for (g = 0; g < LINE_CELLS; g++) line_cells[g] = '0;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------------
  function automatic lbpc_item_t random_word();
    logic [31:0]                   r32;
    logic [$bits(lbpc_item_t)-1:0] raw;
    r32 = $urandom;
    raw = r32[$bits(lbpc_item_t)-1:0];
    return raw;
  endfunction

  function automatic lbpc_item_t store_word(logic os, logic [7:0] pos, logic [2:0] pal,
                                            logic wide, logic hole, logic [7:0] data);
    lbpc_item_t it;
    it                = random_word();
    it.mode           = MODE_STORE;
    it.object_start   = os;
    it.start_position = pos;
    it.palette_select = pal;
    it.wide_mode      = wide;
    it.hole_skip      = hole;
    it.graphic_byte   = data;
    return it;
  endfunction

  // store fields stay random: the block must ignore them here
  function automatic lbpc_item_t color_word(logic [4:0] idx, logic [7:0] val);
    lbpc_item_t it;
    it              = random_word();
    it.mode         = MODE_COLOR;
    it.color_index  = idx;
    it.graphic_byte = val;
    return it;
  endfunction

  function automatic lbpc_item_t emit_word();
    lbpc_item_t it;
    it      = random_word();
    it.mode = MODE_EMIT;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving. Everything changes on the falling edge; tasks start and end
  // there. valid is left high after a word and only dropped by an idle
  // cycle or settle, so it is never lowered and raised in one step.
  // ---------------------------------------------------------------------------
  task automatic send_word(lbpc_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= it.mode;
    in_ch.graphic_byte   <= it.graphic_byte;
    in_ch.object_start   <= it.object_start;
    in_ch.start_position <= it.start_position;
    in_ch.palette_select <= it.palette_select;
    in_ch.wide_mode      <= it.wide_mode;
    in_ch.hole_skip      <= it.hole_skip;
    in_ch.color_index    <= it.color_index;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    model_word(it);
    if (it.mode != MODE_UNUSED) words_sent++;
    @(negedge clk_i);
  endtask

  // Wait for every owed group, then give queued stores time to retire.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_groups.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // All three registers, written back to back while the block is idle.
  task automatic set_config(logic [1:0] dm, logic ck, logic kg);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DISPLAY_MODE;
    cfg_wdata_i <= dm;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_COLOR_KILL;
    cfg_wdata_i <= {1'b0, ck};
    @(negedge clk_i);
    cfg_idx_i   <= CFG_KANGAROO;
    cfg_wdata_i <= {1'b0, kg};
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    disp_mode   = dm;
    kill_color  = ck;
    kangaroo_on = kg;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, forced low during a hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni || hold_on) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Hold-off length is counted here on rising edges, so hold_on never moves
  // on the edge where ready is driven.
  initial begin
    forever begin
      wait (hold_requests != holds_done);
      @(posedge clk_i);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on = 1'b0;
      holds_done++;
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    lbpc_out_t             want;
    logic [7:0][PIX_W-1:0] seen;
    int                    n;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      seen = {out_ch.pixel_7, out_ch.pixel_6, out_ch.pixel_5, out_ch.pixel_4,
              out_ch.pixel_3, out_ch.pixel_2, out_ch.pixel_1, out_ch.pixel_0};
      if (pending_groups.size() == 0) begin
        report_mismatch($sformatf("group word %0d with none expected", out_ch.group_index));
      end else begin
        want = pending_groups.pop_front();
        if (out_ch.group_index !== want.group_index)
          report_mismatch($sformatf("group_index got %0d want %0d",
                                    out_ch.group_index, want.group_index));
        for (n = 0; n < 8; n++) begin
          if (seen[n] !== want.pix[n])
            report_mismatch($sformatf("group %0d pixel_%0d got %h want %h",
                                      want.group_index, n, seen[n], want.pix[n]));
        end
        if (out_ch.last_group !== want.last_group)
          report_mismatch($sformatf("group %0d last_group got %b want %b",
                                    want.group_index, out_ch.last_group, want.last_group));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, each word kind, transparency, holes, line end, wrap,
  // unused mode, kangaroo overwrite, all three pixel forming paths.
  task automatic test_directed();
    lbpc_item_t unused;
    src_idle_pct = 11;
    snk_idle_pct = 86;
    set_config(DM_DOUBLE_A, 1'b0, 1'b0);
    send_word(color_word(5'd0, 8'h80));
    send_word(color_word(5'd31, 8'hFF));
    send_word(color_word(5'd6, 8'h5A));
    send_word(color_word(5'd17, 8'hC3));
    send_word(color_word(5'd29, 8'h3C));
    send_word(store_word(1'b1, 8'd0, 3'd7, 1'b0, 1'b0, 8'hFF));
    // continuation with one transparent pair; start_position must be ignored
    send_word(store_word(1'b0, 8'hAA, 3'd0, 1'b0, 1'b0, 8'h1B));
    send_word(store_word(1'b1, 8'd20, 3'd7, 1'b1, 1'b0, 8'hFF));
    send_word(store_word(1'b0, 8'd0, 3'd4, 1'b1, 1'b0, 8'h00));
    // holes: narrow then wide, then a byte landing after them
    send_word(store_word(1'b1, 8'd40, 3'd3, 1'b0, 1'b1, 8'hFF));
    send_word(store_word(1'b0, 8'd0, 3'd3, 1'b1, 1'b1, 8'hFF));
    send_word(store_word(1'b0, 8'd0, 3'd3, 1'b0, 1'b0, 8'hE4));
    // straddles the end of the line, then wraps from 255 to 0
    send_word(store_word(1'b1, 8'd158, 3'd5, 1'b0, 1'b0, 8'hE4));
    send_word(store_word(1'b1, 8'd254, 3'd6, 1'b0, 1'b0, 8'h6C));
    unused      = random_word();
    unused.mode = MODE_UNUSED;
    send_word(unused);
    send_word(emit_word());

    set_config(DM_PAIR, 1'b1, 1'b1);
    send_word(store_word(1'b1, 8'd0, 3'd2, 1'b0, 1'b0, 8'hD2));
    // transparent cells now clear what was just drawn
    send_word(store_word(1'b1, 8'd0, 3'd1, 1'b0, 1'b0, 8'h00));
    // wide cell with a zero low pair but nonzero high bits
    send_word(store_word(1'b1, 8'd4, 3'd7, 1'b1, 1'b0, 8'h0C));
    send_word(store_word(1'b1, 8'd159, 3'd7, 1'b1, 1'b0, 8'hFF));
    send_word(emit_word());

    set_config(DM_SPLIT, 1'b0, 1'b0);
    send_word(store_word(1'b1, 8'd80, 3'd5, 1'b0, 1'b0, 8'h9C));
    send_word(emit_word());
  endtask

  // One line: colour loads, a few objects of store words, then usually an
  // emit. Some objects lack their start flag, some words are noise.
  task automatic compose_random_line();
    int         n_obj;
    int         n_more;
    int         i;
    int         j;
    logic [2:0] pal;
    logic       wide;
    lbpc_item_t it;
    repeat ($urandom_range(1, 4)) send_word(color_word(5'($urandom_range(31)), 8'($urandom)));
    n_obj = $urandom_range(1, 6);
    for (i = 0; i < n_obj; i++) begin
      pal    = 3'($urandom);
      wide   = 1'($urandom);
      n_more = $urandom_range(0, 5);
      for (j = 0; j <= n_more; j++) begin
        it                = random_word();
        it.mode           = MODE_STORE;
        it.palette_select = pal;
        it.wide_mode      = wide;
        it.object_start   = (j == 0) && ($urandom_range(7) != 0);
        if (it.object_start) begin
          // mostly on the line, sometimes past it or near the wrap
          if ($urandom_range(9) < 8) it.start_position = 8'($urandom_range(LINE_CELLS - 1));
          else it.start_position = 8'($urandom_range(255));
        end
        it.hole_skip = ($urandom_range(7) == 0);
        send_word(it);
        if ($urandom_range(19) == 0) send_word(random_word());
      end
    end
    if ($urandom_range(11) != 0) send_word(emit_word());
  endtask

  // Random lines under one idle profile; settings change between lines.
  task automatic test_random_phase(int src_pct, int snk_pct);
    int goal;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    goal         = words_sent + ITEMS_PER_PHASE;
    while (words_sent < goal) begin
      set_config(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      compose_random_line();
    end
  endtask

  // Receiver holds off long enough for the block to fill and stall its
  // input while the sender keeps offering colour words, stores and emits.
  task automatic test_output_stall();
    int i;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_config(DM_DOUBLE_B, 1'b0, 1'b1);
    hold_requests++;
    for (i = 0; i < 3; i++) begin
      send_word(color_word(5'($urandom_range(31)), 8'($urandom)));
      send_word(store_word(1'b1, 8'($urandom_range(LINE_CELLS - 1)), 3'($urandom),
                           1'($urandom), 1'b0, 8'($urandom)));
      send_word(emit_word());
      send_word(emit_word());
    end
    while (holds_done != hold_requests) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    in_ch.valid          = 1'b0;
    in_ch.mode           = MODE_STORE;
    in_ch.graphic_byte   = '0;
    in_ch.object_start   = 1'b0;
    in_ch.start_position = '0;
    in_ch.palette_select = '0;
    in_ch.wide_mode      = 1'b0;
    in_ch.hole_skip      = 1'b0;
    in_ch.color_index    = '0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_DISPLAY_MODE;
    cfg_wdata_i          = '0;
    for (i = 0; i < LINE_CELLS; i++) line_cells[i] = '0;
    for (i = 0; i < NUM_COLORS; i++) color_regs[i] = '0;
    pen_pos     = '0;
    disp_mode   = DM_DOUBLE_A;
    kill_color  = 1'b0;
    kangaroo_on = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_phase(11, 86);
    test_random_phase(86, 11);
    test_random_phase(0, 0);
    test_output_stall();
    settle();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> line_buffer_pixel_composer.f
+incdir+design
design/lbpc_pkg.sv
design/lbpc_if.sv
design/lbpc_front.sv
design/lbpc_cmd_fifo.sv
design/lbpc_back.sv
design/line_buffer_pixel_composer.sv
design/lbpc_checker.sv
tb/line_buffer_pixel_composer_test.sv
